// ===== src/mdrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Misfire and detection-rate monitor package
// Shared widths, register indexes, field offsets and types.
// ----------------------------------------------------------------------------
`default_nettype none

package mdrm_pkg;

  localparam int WINDOW   = 64;
  localparam int MIN_FILL = 10;
  localparam int CNT_W    = $clog2(WINDOW + 1);

  localparam int ACCEL_W   = 16;
  localparam int SQ_W      = 31;
  localparam int MAG_W     = 32;
  localparam int MTHR_W    = 16;
  localparam int STHR_W    = 17;
  localparam int IDX_W     = 3;
  localparam int FCNT_W    = 7;
  localparam int RATE_SH   = 16;
  localparam int PROD_W    = STHR_W + CNT_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MISFIRE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_THR    = 2'd1;

  localparam logic [MTHR_W-1:0] MTHR_RESET = 16'd256;
  localparam logic [STHR_W-1:0] STHR_RESET = 17'd32768;

  // Input tdata layout.
  localparam int IN_IDX_LO = 0;
  localparam int IN_X_LO   = IN_IDX_LO + IDX_W;
  localparam int IN_Y_LO   = IN_X_LO + ACCEL_W;
  localparam int IN_Z_LO   = IN_Y_LO + ACCEL_W;
  localparam int IN_USED_W = IN_Z_LO + ACCEL_W;
  localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout.
  localparam int OUT_MIS_BIT  = 0;
  localparam int OUT_SENS_BIT = 1;
  localparam int OUT_IDX_LO   = 2;
  localparam int OUT_DET_LO   = OUT_IDX_LO + IDX_W;
  localparam int OUT_FILL_LO  = OUT_DET_LO + FCNT_W;
  localparam int OUT_USED_W   = OUT_FILL_LO + FCNT_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic oldest;
    logic full;
  } win_status_t;

endpackage

`default_nettype wire

// ===== src/misfire_and_detection_rate_monitor_top.sv =====
// ----------------------------------------------------------------------------
// Misfire and detection-rate monitor
// Throughput: one request per cycle while m_axis_tready does not stall the
// output; the squares, the threshold compare with window update, and the rate
// compare each take one pipeline stage.
// Reset: synchronous; clears pipeline valids, counters and cell occupancy and
// loads the register reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module misfire_and_detection_rate_monitor_top (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // trigger_index, accel_x, accel_y, accel_z, zero padding.
  input  wire  [mdrm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // triggered.
  input  wire                                 s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // misfire_alert, sensitivity_alert, alert_index, detections_in_window,
  // window_fill, zero padding.
  output logic [mdrm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [mdrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [mdrm_pkg::STHR_W-1:0]         cfg_data
);

  import mdrm_pkg::*;

  logic [MTHR_W-1:0] misfire_thr;
  logic [STHR_W-1:0] sens_thr;
  logic [MAG_W-1:0]  thr2;

  logic              v1, v2, v3;
  logic              adv1, adv2, adv3;

  logic              trig1;
  logic [IDX_W-1:0]  idx1;
  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;

  logic              mis2;
  logic [IDX_W-1:0]  idx2;
  logic [CNT_W-1:0]  ones_count, ones_count_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;

  logic              mis3, sens3;
  logic [IDX_W-1:0]  idx3;
  logic [FCNT_W-1:0] det3, fill3;

  logic signed [ACCEL_W-1:0]   ax, ay, az;
  logic signed [2*ACCEL_W-1:0] px, py, pz;
  logic [MAG_W-1:0]  mag2;
  logic              below, det, drop;
  logic              fill_ok, rate_low;
  logic [PROD_W-1:0] lhs, rhs;
  win_status_t       win_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      misfire_thr <= MTHR_RESET;
      sens_thr    <= STHR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MISFIRE_THR: misfire_thr <= cfg_data[MTHR_W-1:0];
        REG_SENS_THR:    sens_thr    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr2 <= MAG_W'(misfire_thr) * MAG_W'(misfire_thr);
  end

  assign adv3 = !v3 || m_axis_tready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_axis_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  assign ax = s_axis_tdata[IN_X_LO +: ACCEL_W];
  assign ay = s_axis_tdata[IN_Y_LO +: ACCEL_W];
  assign az = s_axis_tdata[IN_Z_LO +: ACCEL_W];
  assign px = ax * ax;
  assign py = ay * ay;
  assign pz = az * az;

  always_ff @(posedge clk) begin
    if (adv1) begin
      trig1 <= s_axis_tuser;
      idx1  <= s_axis_tdata[IN_IDX_LO +: IDX_W];
      sq_x  <= px[SQ_W-1:0];
      sq_y  <= py[SQ_W-1:0];
      sq_z  <= pz[SQ_W-1:0];
    end
  end

  assign mag2  = MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);
  assign below = mag2 < thr2;
  assign det   = trig1 && !below;
  assign drop  = win_status.full && win_status.oldest;

  assign ones_count_next = ones_count - CNT_W'(drop) + CNT_W'(det);
  assign fill_count_next = win_status.full ? fill_count : CNT_W'(fill_count + 1'b1);

  mdrm_window u_window (
    .clk      (clk),
    .rst      (rst),
    .push     (adv2 && v1),
    .push_det (det),
    .status   (win_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_count <= '0;
      fill_count <= '0;
    end else if (adv2 && v1) begin
      ones_count <= ones_count_next;
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      mis2 <= trig1 && below;
      idx2 <= (trig1 && below) ? idx1 : '0;
    end
  end

  assign fill_ok  = fill_count >= CNT_W'(MIN_FILL);
  assign lhs      = PROD_W'(ones_count) << RATE_SH;
  assign rhs      = PROD_W'(sens_thr) * PROD_W'(fill_count);
  assign rate_low = lhs < rhs;

  always_ff @(posedge clk) begin
    if (adv3) begin
      mis3  <= mis2;
      sens3 <= fill_ok && rate_low;
      idx3  <= idx2;
      det3  <= FCNT_W'(ones_count);
      fill3 <= FCNT_W'(fill_count);
    end
  end

  assign m_axis_tvalid = v3;

  always_comb begin
    m_axis_tdata                          = '0;
    m_axis_tdata[OUT_MIS_BIT]             = mis3;
    m_axis_tdata[OUT_SENS_BIT]            = sens3;
    m_axis_tdata[OUT_IDX_LO +: IDX_W]     = idx3;
    m_axis_tdata[OUT_DET_LO +: FCNT_W]    = det3;
    m_axis_tdata[OUT_FILL_LO +: FCNT_W]   = fill3;
  end

endmodule

`default_nettype wire

// ===== src/mdrm_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one detection bit and its occupancy flag, shifting to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mdrm_cell (
  input  wire  clk,
  input  wire  rst,
  input  wire  shift,
  input  wire  det_in,
  input  wire  used_in,
  output logic det_q,
  output logic used_q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      det_q <= det_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_q <= 1'b0;
    end else if (shift) begin
      used_q <= used_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/mdrm_window.sv =====
// ----------------------------------------------------------------------------
// Detection window
// A chain of cells; each request shifts a new bit in and the oldest one out.
// ----------------------------------------------------------------------------
`default_nettype none

module mdrm_window (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire                  push_det,
  output mdrm_pkg::win_status_t status
);

  import mdrm_pkg::*;

  logic det_chain  [WINDOW];
  logic used_chain [WINDOW];

  genvar i;
  generate
    for (i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
        mdrm_cell u_cell (
          .clk     (clk),
          .rst     (rst),
          .shift   (push),
          .det_in  (push_det),
          .used_in (1'b1),
          .det_q   (det_chain[i]),
          .used_q  (used_chain[i])
        );
      end else begin : g_body
        mdrm_cell u_cell (
          .clk     (clk),
          .rst     (rst),
          .shift   (push),
          .det_in  (det_chain[i-1]),
          .used_in (used_chain[i-1]),
          .det_q   (det_chain[i]),
          .used_q  (used_chain[i])
        );
      end
    end
  endgenerate

  assign status.oldest = det_chain[WINDOW-1];
  assign status.full   = used_chain[WINDOW-1];

endmodule

`default_nettype wire

// ===== src/mdrm_checker.sv =====
// ----------------------------------------------------------------------------
// Monitor port checker
// Port-level properties of the monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mdrm_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [mdrm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  import mdrm_pkg::*;

  logic              mis;
  logic              sens;
  logic [IDX_W-1:0]  idx;
  logic [FCNT_W-1:0] det_cnt;
  logic [FCNT_W-1:0] fill_cnt;

  assign mis      = m_axis_tdata[OUT_MIS_BIT];
  assign sens     = m_axis_tdata[OUT_SENS_BIT];
  assign idx      = m_axis_tdata[OUT_IDX_LO +: IDX_W];
  assign det_cnt  = m_axis_tdata[OUT_DET_LO +: FCNT_W];
  assign fill_cnt = m_axis_tdata[OUT_FILL_LO +: FCNT_W];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_idx_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !mis) |-> (idx == '0))
    else $error("alert index set without a misfire");

  a_det_le_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (det_cnt <= fill_cnt))
    else $error("more detections than window entries");

  a_sens_fill: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && sens) |-> (fill_cnt >= FCNT_W'(MIN_FILL)))
    else $error("sensitivity alert with too few entries");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind misfire_and_detection_rate_monitor_top mdrm_checker u_mdrm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Misfire and detection-rate monitor testbench
// Drives sensor samples and register writes into the monitor. The testbench
// keeps its own model of the detection window and the thresholds, and checks
// every result field against it or the table. A short directed table covers
// threshold boundaries, extreme accelerations and register corner values.
// Random phases with varied settings and random idling on both sides follow.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mdrm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 3;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 205;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    bit                 trig;
    bit [IDX_W-1:0]     idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } sample_t;

  typedef struct {
    bit              misfire;
    bit              sens;
    bit [IDX_W-1:0]  idx;
    bit [FCNT_W-1:0] det;
    bit [FCNT_W-1:0] fill;
  } alert_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  sel;
    logic [STHR_W-1:0]     value;
    sample_t               s;
    bit                    typed;
    alert_t                want;
  } stim_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [STHR_W-1:0]     cfg_data = '0;

  // Model state.
  logic [MTHR_W-1:0] misfire_thr = MTHR_RESET;
  logic [STHR_W-1:0] rate_thr    = STHR_RESET;
  bit                win_bits [WINDOW];
  int                next_slot;
  int                held;
  int                ones;

  alert_t    pending_alerts [$];
  stim_row_t stim_rows [$];
  int        errors;
  int        samples_sent;
  int        writes_done;
  int        misfires_seen;
  int        sens_seen;
  bit        steady;

  misfire_and_detection_rate_monitor_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_alerts.size());
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic void update_register(logic [CFG_IDX_W-1:0] sel,
                                          logic [STHR_W-1:0] value);
    case (sel)
      REG_MISFIRE_THR: begin
        misfire_thr = value[MTHR_W-1:0];
      end
      REG_SENS_THR: begin
        rate_thr = value;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic alert_t advance_window(sample_t s);
    alert_t a;
    longint mag2;
    longint thr2;
    bit     below;
    bit     det_bit;
    mag2 = longint'(s.x) * s.x + longint'(s.y) * s.y + longint'(s.z) * s.z;
    thr2 = longint'(misfire_thr) * longint'(misfire_thr);
    below = mag2 < thr2;
    det_bit = s.trig && !below;
    if (held >= WINDOW) begin
      ones -= int'(win_bits[next_slot]);
    end else begin
      held++;
    end
    win_bits[next_slot] = det_bit;
    ones += int'(det_bit);
    next_slot = (next_slot + 1) % WINDOW;
    a.misfire = s.trig && below;
    a.sens = (held >= MIN_FILL) &&
             (longint'(ones) * 65536 < longint'(rate_thr) * held);
    a.idx  = a.misfire ? s.idx : '0;
    a.det  = ones[FCNT_W-1:0];
    a.fill = held[FCNT_W-1:0];
    return a;
  endfunction

  function automatic sample_t make_sample(bit trig, int idx, int x, int y, int z);
    sample_t s;
    s.trig = trig;
    s.idx  = idx[IDX_W-1:0];
    s.x    = x[15:0];
    s.y    = y[15:0];
    s.z    = z[15:0];
    return s;
  endfunction

  function automatic stim_row_t sample_row(bit trig, int idx, int x, int y, int z);
    stim_row_t r;
    r.kind  = ROW_SAMPLE;
    r.sel   = '0;
    r.value = '0;
    r.s     = make_sample(trig, idx, x, y, z);
    r.typed = 1'b0;
    r.want  = '{default: '0};
    return r;
  endfunction

  function automatic stim_row_t checked_row(bit trig, int idx, int x, int y, int z,
                                            bit mis, bit sens, int aidx, int det,
                                            int fill);
    stim_row_t r;
    r = sample_row(trig, idx, x, y, z);
    r.typed = 1'b1;
    r.want.misfire = mis;
    r.want.sens    = sens;
    r.want.idx     = aidx[IDX_W-1:0];
    r.want.det     = det[FCNT_W-1:0];
    r.want.fill    = fill[FCNT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] sel, int value);
    stim_row_t r;
    r = sample_row(1'b0, 0, 0, 0, 0);
    r.kind  = ROW_WRITE;
    r.sel   = sel;
    r.value = value[STHR_W-1:0];
    return r;
  endfunction

  function automatic void append_row(stim_row_t r);
    stim_rows = {stim_rows, r};
  endfunction

  function automatic sample_t random_sample(int trig_pct);
    int lim;
    int comp [3];
    int mode;
    int axis;
    lim = (misfire_thr == 0) ? 1 : (misfire_thr > 32767 ? 32767 : int'(misfire_thr));
    mode = $urandom_range(0, 9);
    comp = '{0, 0, 0};
    if (mode < 3) begin
      foreach (comp[i]) comp[i] = $urandom_range(0, 65535) - 32768;
    end else if (mode < 5) begin
      axis = $urandom_range(0, 2);
      comp[axis] = lim + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) comp[axis] = -comp[axis];
    end else begin
      foreach (comp[i]) comp[i] = $urandom_range(0, 2 * lim) - lim;
    end
    return make_sample($urandom_range(0, 99) < trig_pct, $urandom_range(0, 7),
                       comp[0], comp[1], comp[2]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_sample(sample_t s, bit typed, alert_t want);
    int     gap;
    alert_t a;
    logic [IN_DATA_W-1:0] d;
    gap = pick_gap();
    d = '0;
    d[IN_IDX_LO +: IDX_W] = s.idx;
    d[IN_X_LO +: ACCEL_W] = s.x;
    d[IN_Y_LO +: ACCEL_W] = s.y;
    d[IN_Z_LO +: ACCEL_W] = s.z;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= s.trig;
    do @(posedge clk); while (!s_axis_tready);
    a = advance_window(s);
    if (typed) a = want;
    pending_alerts = {pending_alerts, a};
    samples_sent++;
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_alerts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] sel, logic [STHR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    update_register(sel, value);
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result receiver: random stalls, bursts of steady acceptance.
  initial begin
    int len;
    @(negedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      len = steady ? 1 : $urandom_range(1, 40);
      repeat (len) @(negedge clk);
      len = pick_gap();
      if (len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (len) @(negedge clk);
      end
    end
  end

  initial begin
    alert_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_alerts.size() == 0) begin
          report_mismatch("result with nothing pending", int'(m_axis_tdata), 0);
        end else begin
          want = pending_alerts.pop_front();
          if (m_axis_tdata[OUT_MIS_BIT] != want.misfire)
            report_mismatch("misfire_alert", int'(m_axis_tdata[OUT_MIS_BIT]),
                            int'(want.misfire));
          if (m_axis_tdata[OUT_SENS_BIT] != want.sens)
            report_mismatch("sensitivity_alert", int'(m_axis_tdata[OUT_SENS_BIT]),
                            int'(want.sens));
          if (m_axis_tdata[OUT_IDX_LO +: IDX_W] != want.idx)
            report_mismatch("alert_index", int'(m_axis_tdata[OUT_IDX_LO +: IDX_W]),
                            int'(want.idx));
          if (m_axis_tdata[OUT_DET_LO +: FCNT_W] != want.det)
            report_mismatch("detections_in_window",
                            int'(m_axis_tdata[OUT_DET_LO +: FCNT_W]), int'(want.det));
          if (m_axis_tdata[OUT_FILL_LO +: FCNT_W] != want.fill)
            report_mismatch("window_fill", int'(m_axis_tdata[OUT_FILL_LO +: FCNT_W]),
                            int'(want.fill));
          misfires_seen += int'(want.misfire);
          sens_seen += int'(want.sens);
        end
      end
    end
  end

  initial begin
    int mis_set  [PHASES];
    int rate_set [PHASES];
    int trig_pct;
    int v;
    alert_t none;

    mis_set  = '{256, -1, 65535, 0, -2, 1, -1};
    rate_set = '{32768, -1, 65536, 0, 131071, 1, -1};
    none = '{default: '0};
    foreach (win_bits[i]) win_bits[i] = 1'b0;

    // After reset the thresholds are 1.0 m/s^2 and a rate of one half.
    append_row(checked_row(0, 5, 0, 0, 0, 0, 0, 0, 0, 1));
    append_row(checked_row(1, 7, 0, 0, 0, 1, 0, 7, 0, 2));
    append_row(checked_row(1, 3, -32768, -32768, -32768, 0, 0, 0, 1, 3));
    append_row(checked_row(1, 1, 32767, 32767, 32767, 0, 0, 0, 2, 4));
    append_row(checked_row(1, 6, 256, 0, 0, 0, 0, 0, 3, 5));
    append_row(checked_row(1, 2, 255, 0, 0, 1, 0, 2, 3, 6));
    append_row(checked_row(1, 4, 0, -256, 0, 0, 0, 0, 4, 7));
    append_row(checked_row(0, 7, 12345, -4321, 999, 0, 0, 0, 4, 8));
    append_row(checked_row(0, 0, 0, 0, -32768, 0, 0, 0, 4, 9));
    append_row(checked_row(0, 1, 0, 0, 0, 0, 1, 0, 4, 10));
    append_row(write_row(REG_MISFIRE_THR, 0));
    append_row(checked_row(1, 5, 0, 0, 0, 0, 1, 0, 5, 11));
    append_row(write_row(REG_SENS_THR, 131071));
    append_row(checked_row(1, 0, -1, -1, -1, 0, 1, 0, 6, 12));
    append_row(write_row(REG_SENS_THR, 0));
    append_row(checked_row(1, 1, 1, 0, 0, 0, 0, 0, 7, 13));
    append_row(write_row(REG_SPARE_A, 'h1ABCD));
    append_row(write_row(REG_SPARE_B, 'h0FFFF));
    append_row(write_row(REG_MISFIRE_THR, 'h1FFFF));
    append_row(checked_row(1, 7, -32768, -32768, -32768, 1, 0, 7, 7, 14));
    append_row(write_row(REG_SENS_THR, 65536));
    append_row(checked_row(0, 3, 32767, 32767, 32767, 0, 1, 0, 7, 15));
    append_row(sample_row(1, 6, -200, 150, 100));
    append_row(write_row(REG_MISFIRE_THR, 256));
    append_row(write_row(REG_SENS_THR, 32768));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        drain_pipeline();
        write_register(stim_rows[i].sel, stim_rows[i].value);
      end else begin
        send_sample(stim_rows[i].s, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_pipeline();
      steady = (p == 2);
      v = mis_set[p];
      if (v == -1) v = $urandom_range(0, 65535);
      if (v == -2) v = $urandom_range(1, 2000);
      write_register(REG_MISFIRE_THR, v);
      v = rate_set[p];
      if (v < 0) v = $urandom_range(0, 131071);
      write_register(REG_SENS_THR, v);
      trig_pct = $urandom_range(30, 100);
      repeat (PHASE_ITEMS) send_sample(random_sample(trig_pct), 1'b0, none);
    end

    drain_pipeline();
    $display("%0d samples and %0d register writes checked", samples_sent, writes_done);
    $display("%0d misfire alerts and %0d sensitivity alerts expected along the way",
             misfires_seen, sens_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
